// ===== rtl/simt_active_mask_stack_macros.svh =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SIMT_ACTIVE_MASK_STACK_MACROS_SVH
`define SIMT_ACTIVE_MASK_STACK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAMS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAMS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sams_pkg.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - package
// Operation and error codes, the command that travels from front to back,
// and the digest constants.
// ----------------------------------------------------------------------------
package sams_pkg;

   typedef enum logic [2:0] {
      OP_PUSH          = 3'd0,
      OP_POP           = 3'd1,
      OP_SET_ACTIVE    = 3'd2,
      OP_SET_PREDICATE = 3'd3,
      OP_QUERY         = 3'd4,
      OP_DIGEST        = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2,
      ERR_LANE      = 2'd3
   } err_type;

   typedef struct packed {
      op_type      op;
      logic        lane_chk;   // the action needs an in-range lane
      logic        lane_ok;    // the lane is below the lanes in use
      logic [5:0]  lane;
      logic        bit_value;
      logic [4:0]  pop_levels;
      logic [31:0] mix;        // digest term, count and address folded
   } cmd_type;

   localparam logic [31:0] DIGEST_MUL_COUNT   = 32'h4919f71f;
   localparam logic [31:0] DIGEST_MUL_ADDRESS = 32'h31f2e73b;
   localparam logic [6:0]  LANES_IN_USE_RESET = 7'd64;

endpackage

// ===== rtl/simt_active_mask_stack.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - top level
// Divergence unit for one wavefront: mask stack, predicates, lane digests.
// ----------------------------------------------------------------------------
// An item is offered on the req_ ports with start, and is taken at a rising
// edge where start is high and busy is low. Each item gives exactly one
// result, shown on the rsp_ ports for a single cycle with rsp_strobe high.
// The receiver cannot hold results off, so it must take every strobe.
// The front end registers the item, decodes it and forms the digest term
// with two multipliers; a two-entry queue then passes the command to the
// back end, which reads the stack and digest memories as it takes the
// command and updates the state in the cycle after. Busy falls as the
// strobe rises, so a new item is taken only once the result of the last
// one is shown. On its way an item passes the front end's input register,
// the queue entry, and the memory read and execute steps of the back end.
// Reset clears the stack, the top index, the predicates and the digests
// (digests through valid bits) and sets lanes in use to 64; no clearing
// pass is needed. csr_wr_data may be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "simt_active_mask_stack_macros.svh"

module simt_active_mask_stack #(
   parameter int LANES       = 64,
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Item channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_lane,
   input  logic        req_bit_value,
   input  logic [4:0]  req_pop_levels,
   input  logic [31:0] req_instruction_count,
   input  logic [31:0] req_instruction_address,
   // Result channel
   output logic        rsp_strobe,
   output logic        rsp_lane_active,
   output logic        rsp_lane_predicate,
   output logic [31:0] rsp_lane_digest,
   output logic [4:0]  rsp_stack_level,
   output logic [1:0]  rsp_error_code,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   logic              busy_ff, busy_in;
   logic [6:0]        lanes_in_use_ff;
   logic              accept;
   logic              q_push, q_pop, q_empty, q_full;
   logic              back_done;
   sams_pkg::cmd_type q_in, q_head;
   logic              rsp_lane_err, rsp_lane_zero;

   // An item stays outstanding from acceptance until its result is shown.
   assign accept  = start && !busy_ff;
   assign busy_in = accept || (busy_ff && !back_done);
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         lanes_in_use_ff <= sams_pkg::LANES_IN_USE_RESET;
      end else begin
         busy_ff <= busy_in;
         if (csr_wr_en) begin
            lanes_in_use_ff <= csr_wr_data;
         end
      end
   end

   sams_front #(
      .LANES (LANES)
   ) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .accept                  (accept),
      .req_action              (req_action),
      .req_lane                (req_lane),
      .req_bit_value           (req_bit_value),
      .req_pop_levels          (req_pop_levels),
      .req_instruction_count   (req_instruction_count),
      .req_instruction_address (req_instruction_address),
      .lanes_in_use            (lanes_in_use_ff),
      .q_full                  (q_full),
      .q_push                  (q_push),
      .q_data                  (q_in)
   );

   sams_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   sams_back #(
      .LANES       (LANES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .done               (back_done),
      .rsp_strobe         (rsp_strobe),
      .rsp_lane_active    (rsp_lane_active),
      .rsp_lane_predicate (rsp_lane_predicate),
      .rsp_lane_digest    (rsp_lane_digest),
      .rsp_stack_level    (rsp_stack_level),
      .rsp_error_code     (rsp_error_code)
   );

   // Terms for the range-error check below.
   assign rsp_lane_err  = rsp_strobe && (rsp_error_code == sams_pkg::ERR_LANE);
   assign rsp_lane_zero = !rsp_lane_active && !rsp_lane_predicate && (rsp_lane_digest == 32'd0);

   // A result never follows another directly, since each needs a new item.
   `SAMS_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result repeated")
   // The item is finished by the time its result is shown.
   `SAMS_ASSERT_SAME(a_strobe_not_busy, rsp_strobe, !busy, "result while item outstanding")
   // A fresh item cannot produce a result in the next cycle.
   `SAMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_strobe, "accept lost")
   // A lane out of range reports all of its lane fields as zero.
   `SAMS_ASSERT_SAME(a_lane_err_zero, rsp_lane_err, rsp_lane_zero, "lane fields set on range error")

endmodule

// ===== rtl/sams_ram.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sams_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sams_queue.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - command queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module sams_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sams_pkg::cmd_type push_data,
   input  logic              pop,
   output sams_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   sams_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sams_front.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - front end
// Takes in an item, decodes the action, checks the lane against the lanes in
// use and forms the digest term, then hands a command to the queue.
// ----------------------------------------------------------------------------
module sams_front #(
   parameter int LANES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        req_action,
   input  logic [5:0]        req_lane,
   input  logic              req_bit_value,
   input  logic [4:0]        req_pop_levels,
   input  logic [31:0]       req_instruction_count,
   input  logic [31:0]       req_instruction_address,
   input  logic [6:0]        lanes_in_use,
   input  logic              q_full,
   output logic              q_push,
   output sams_pkg::cmd_type q_data
);

   localparam logic [6:0] LanesMax = 7'(LANES);

   logic              s1_valid_ff, s1_valid_in;
   sams_pkg::cmd_type cmd_ff, cmd_in;
   logic [31:0]       prod_count_ff, prod_count_in;
   logic [31:0]       prod_addr_ff, prod_addr_in;
   logic [6:0]        lanes_used;

   assign lanes_used = (lanes_in_use < LanesMax) ? lanes_in_use : LanesMax;

   always_comb begin
      cmd_in            = '0;
      cmd_in.lane       = req_lane;
      cmd_in.bit_value  = req_bit_value;
      cmd_in.pop_levels = req_pop_levels;
      cmd_in.lane_ok    = ({1'b0, req_lane} < lanes_used);
      cmd_in.lane_chk   = req_action inside {[sams_pkg::OP_SET_ACTIVE:sams_pkg::OP_DIGEST]};
      case (req_action)
         sams_pkg::OP_PUSH:          cmd_in.op = sams_pkg::OP_PUSH;
         sams_pkg::OP_POP:           cmd_in.op = sams_pkg::OP_POP;
         sams_pkg::OP_SET_ACTIVE:    cmd_in.op = sams_pkg::OP_SET_ACTIVE;
         sams_pkg::OP_SET_PREDICATE: cmd_in.op = sams_pkg::OP_SET_PREDICATE;
         sams_pkg::OP_QUERY:         cmd_in.op = sams_pkg::OP_QUERY;
         sams_pkg::OP_DIGEST:        cmd_in.op = sams_pkg::OP_DIGEST;
         default:                    cmd_in.op = sams_pkg::OP_QUERY;   // unused codes only report
      endcase
      prod_count_in = req_instruction_count * sams_pkg::DIGEST_MUL_COUNT;
      prod_addr_in  = req_instruction_address * sams_pkg::DIGEST_MUL_ADDRESS;
   end

   always_comb begin
      q_push      = s1_valid_ff && !q_full;
      q_data      = cmd_ff;
      q_data.mix  = prod_count_ff + prod_addr_ff;
      s1_valid_in = accept || (s1_valid_ff && !q_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= cmd_in;
         prod_count_ff <= prod_count_in;
         prod_addr_ff  <= prod_addr_in;
      end
   end

endmodule

// ===== rtl/sams_back.sv =====
// ----------------------------------------------------------------------------
// SIMT active mask stack - back end
// Holds the stack, predicate mask and digests and carries out one command
// at a time: a memory read as the command leaves the queue, then an execute
// step that updates the state and registers the result.
// ----------------------------------------------------------------------------
module sams_back #(
   parameter int LANES       = 64,
   parameter int STACK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sams_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              done,
   output logic              rsp_strobe,
   output logic              rsp_lane_active,
   output logic              rsp_lane_predicate,
   output logic [31:0]       rsp_lane_digest,
   output logic [4:0]        rsp_stack_level,
   output logic [1:0]        rsp_error_code
);

   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = (SW > 5) ? SW : 5;
   localparam logic [SW-1:0] TopMax = SW'(STACK_DEPTH - 1);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_EXEC = 2'b10
   } bk_state_type;

   bk_state_type      state_ff, state_in;
   sams_pkg::cmd_type cmd_ff;
   logic [SW-1:0]     top_ff, top_in;
   logic [LANES-1:0]  top_mask_ff, top_mask_in;
   logic [LANES-1:0]  pred_ff, pred_in;
   logic [LANES-1:0]  dig_valid_ff, dig_valid_in;

   logic              rsp_strobe_ff;
   logic              rsp_active_ff, rsp_active_in;
   logic              rsp_pred_ff, rsp_pred_in;
   logic [31:0]       rsp_digest_ff, rsp_digest_in;
   logic [4:0]        rsp_level_ff, rsp_level_in;
   sams_pkg::err_type rsp_err_ff, err_in;

   logic [LW-1:0]     lane_idx;
   logic [CW-1:0]     rd_base;
   logic [CW-1:0]     lev_ext, top_ext, pop_diff;
   logic [CW-1:0]     top_new_ext;
   logic [LANES-1:0]  stk_q;
   logic [31:0]       dig_q, dig_cur, dig_new;
   logic              stk_we, dig_we, exec;

   assign exec     = (state_ff == BK_EXEC);
   assign q_pop    = (state_ff == BK_IDLE) && !q_empty;
   assign done     = exec;
   assign lane_idx = cmd_ff.lane[LW-1:0];

   // The pop target level is read while the command leaves the queue.
   assign rd_base = CW'(top_ff) - CW'(q_head.pop_levels);

   sams_ram #(
      .WIDTH (LANES),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (top_ff),
      .wr_data (top_mask_ff),
      .rd_en   (q_pop),
      .rd_addr (rd_base[SW-1:0]),
      .rd_data (stk_q)
   );

   sams_ram #(
      .WIDTH (32),
      .DEPTH (LANES)
   ) u_digest_ram (
      .clock   (clock),
      .wr_en   (dig_we),
      .wr_addr (lane_idx),
      .wr_data (dig_new),
      .rd_en   (q_pop),
      .rd_addr (q_head.lane[LW-1:0]),
      .rd_data (dig_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      lev_ext      = CW'(cmd_ff.pop_levels);
      top_ext      = CW'(top_ff);
      pop_diff     = top_ext - lev_ext;
      dig_cur      = dig_valid_ff[lane_idx] ? dig_q : 32'd0;
      dig_new      = dig_cur;
      top_in       = top_ff;
      top_mask_in  = top_mask_ff;
      pred_in      = pred_ff;
      dig_valid_in = dig_valid_ff;
      err_in       = sams_pkg::ERR_OK;
      stk_we       = 1'b0;
      dig_we       = 1'b0;
      if (exec) begin
         if (cmd_ff.lane_chk && !cmd_ff.lane_ok) begin
            err_in = sams_pkg::ERR_LANE;
         end else begin
            case (cmd_ff.op)
               sams_pkg::OP_PUSH: begin
                  if (top_ff == TopMax) begin
                     err_in = sams_pkg::ERR_OVERFLOW;
                  end else begin
                     stk_we = 1'b1;
                     top_in = top_ff + 1'b1;
                  end
               end
               sams_pkg::OP_POP: begin
                  if (lev_ext != '0) begin
                     if (lev_ext > top_ext) begin
                        err_in = sams_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_in      = pop_diff[SW-1:0];
                        top_mask_in = stk_q;
                     end
                  end
               end
               sams_pkg::OP_SET_ACTIVE:    top_mask_in[lane_idx] = cmd_ff.bit_value;
               sams_pkg::OP_SET_PREDICATE: pred_in[lane_idx] = cmd_ff.bit_value;
               sams_pkg::OP_DIGEST: begin
                  if (top_mask_ff[lane_idx]) begin
                     dig_new                = dig_cur ^ cmd_ff.mix;
                     dig_we                 = 1'b1;
                     dig_valid_in[lane_idx] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
      top_new_ext   = CW'(top_in);
      rsp_level_in  = top_new_ext[4:0];
      rsp_active_in = cmd_ff.lane_ok && top_mask_in[lane_idx];
      rsp_pred_in   = cmd_ff.lane_ok && pred_in[lane_idx];
      rsp_digest_in = cmd_ff.lane_ok ? dig_new : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         top_ff        <= '0;
         top_mask_ff   <= '0;
         pred_ff       <= '0;
         dig_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         top_mask_ff   <= top_mask_in;
         pred_ff       <= pred_in;
         dig_valid_ff  <= dig_valid_in;
         rsp_strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
      end
      if (exec) begin
         rsp_active_ff <= rsp_active_in;
         rsp_pred_ff   <= rsp_pred_in;
         rsp_digest_ff <= rsp_digest_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_err_ff    <= err_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_lane_active    = rsp_active_ff;
   assign rsp_lane_predicate = rsp_pred_ff;
   assign rsp_lane_digest    = rsp_digest_ff;
   assign rsp_stack_level    = rsp_level_ff;
   assign rsp_error_code     = rsp_err_ff;

endmodule
